@@ design/i2cbm_pkg.sv @@
// shared types and constants for the byte-level i2c master
`default_nettype none

package i2cbm_pkg;

  // counter width default and register reset value
  localparam int          TICK_CNT_W_DEF    = 16;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd320;

  // phase numbering
  localparam int          PHASE_W       = 5;
  localparam logic [4:0]  PH_BIT_END    = 5'd16;
  localparam logic [4:0]  PH_RELEASE    = 5'd17;
  localparam logic [4:0]  PH_START_CNT  = 5'd1;
  localparam logic [4:0]  PH_STOP_CNT   = 5'd3;
  localparam logic [4:0]  PH_WRITE_CNT  = 5'd19;
  localparam logic [4:0]  PH_READ_CNT   = 5'd18;

  // command codes
  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  // input transaction: one clock tick
  typedef struct packed {
    logic       cmd_valid;
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  // result transaction: line drivers and status after the tick
  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_seen;
  } out_t;

  // number of phases in each command
  function automatic logic [4:0] phase_total(input kind_t k);
    logic [4:0] n;
    unique case (k)
      KIND_START: n = PH_START_CNT;
      KIND_STOP:  n = PH_STOP_CNT;
      KIND_WRITE: n = PH_WRITE_CNT;
      KIND_READ:  n = PH_READ_CNT;
      default:    n = PH_START_CNT;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

@@ design/i2c_byte_level_master_core.sv @@
// top level of the byte-level i2c master: phase sequencer and result register
//
// Usage: every input transaction is one tick of the bus phase timer. While the
// master is idle, a tick with cmd_valid set starts a start, stop, write-byte or
// read-byte command; commands offered while busy are dropped. Each tick gives
// exactly one result transaction carrying the scl/sda pull-down controls, busy,
// done, the byte gathered by the latest read and the latest write's ack.
// Each result is loaded into a single output register when its tick is
// accepted. Throughput: one tick per cycle; the sequencer state and the
// output register both update in the accepting cycle, so in_ready only drops
// while a result is held and out_ready is low. A stalled receiver simply
// holds the result; the sequencer freezes with it, since time only advances
// on accepted ticks.
// cfg_we writes the ticks-per-phase register (0 acts as 1) at any edge; it is
// meant to be changed only while idle.
// Reset (synchronous, rst_n low): idle, both lines released, counters, rx byte
// and ack cleared, phase length back to 320 ticks.
`default_nettype none

module i2c_byte_level_master_core
  import i2cbm_pkg::*;
#(
  parameter int TICK_COUNTER_WIDTH = TICK_CNT_W_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata
);

  localparam int CntW = TICK_COUNTER_WIDTH;
  localparam int LimW = (CntW > 16) ? CntW : 16;

  // bus state touched by phase entry
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       ack;
    logic [7:0] rx;
  } bus_t;

  // apply the line actions of phase p of command k
  function automatic bus_t enter_phase(input kind_t k, input logic [4:0] p,
                                       input logic sda_in, input logic [7:0] shb,
                                       input logic ackreq, input bus_t cur);
    bus_t       b;
    logic [2:0] bitpos;
    b      = cur;
    bitpos = ~p[3:1];
    unique case (k)
      KIND_START: b.sda = 1'b1;
      KIND_STOP: begin
        if (p == 5'd0) begin
          b.scl = 1'b1;
          b.sda = 1'b1;
        end else if (p == 5'd1) begin
          b.scl = 1'b0;
        end else begin
          b.sda = 1'b0;
        end
      end
      KIND_WRITE: begin
        if (p < PH_BIT_END) begin
          if (!p[0]) begin
            b.scl = 1'b1;
            b.sda = ~shb[bitpos];
          end else begin
            b.scl = 1'b0;
          end
        end else if (p == PH_BIT_END) begin
          b.scl = 1'b1;
          b.sda = 1'b0;
        end else if (p == PH_RELEASE) begin
          b.scl = 1'b0;
        end else begin
          b.ack = ~sda_in;
        end
      end
      KIND_READ: begin
        if (p < PH_BIT_END) begin
          if (!p[0]) begin
            b.scl = 1'b1;
            b.sda = 1'b0;
          end else begin
            b.scl = 1'b0;
            b.rx[bitpos] = sda_in;
          end
        end else if (p == PH_BIT_END) begin
          b.scl = 1'b1;
          if (ackreq) b.sda = 1'b1;
        end else begin
          b.scl = 1'b0;
        end
      end
      default: b = cur;
    endcase
    return b;
  endfunction

  // state registers
  logic [15:0]      phase_ticks_r;
  logic [4:0]       phase_r, phase_nxt;
  logic [CntW-1:0]  tick_r, tick_nxt;
  kind_t            kind_r, kind_nxt;
  logic             busy_r, busy_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic             ackreq_r, ackreq_nxt;
  bus_t             bus_r, bus_nxt;
  logic             out_valid_r;
  out_t             out_data_r, out_data_nxt;
  logic             done_nxt;

  // phase length, clamped to the counter and to at least one tick
  logic [LimW-1:0]  ticks_ext, cap_ext, lim_ext;
  logic [CntW-1:0]  lim;

  always_comb begin
    ticks_ext = LimW'(phase_ticks_r);
    cap_ext   = LimW'({CntW{1'b1}});
    lim_ext   = (ticks_ext > cap_ext) ? cap_ext : ticks_ext;
    if (lim_ext == '0) lim_ext = LimW'(1);
    lim = lim_ext[CntW-1:0];
  end

  // handshake: accept whenever the result register is free or being drained
  logic accept;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // one tick of the sequencer
  logic [CntW-1:0] tick_inc;
  logic [4:0]      phase_inc;
  bus_t            bus_st;

  always_comb begin
    kind_nxt   = kind_r;
    shift_nxt  = shift_r;
    ackreq_nxt = ackreq_r;
    busy_nxt   = busy_r;
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bus_st     = bus_r;
    bus_nxt    = bus_r;
    done_nxt   = 1'b0;
    tick_inc   = '0;
    phase_inc  = '0;

    // command launch applies phase zero
    if (!busy_r && in_data.cmd_valid) begin
      kind_nxt   = in_data.kind;
      shift_nxt  = in_data.tx_byte;
      ackreq_nxt = in_data.send_ack;
      busy_nxt   = 1'b1;
      phase_nxt  = '0;
      tick_nxt   = '0;
      bus_st     = enter_phase(in_data.kind, 5'd0, in_data.sda_in, in_data.tx_byte,
                               in_data.send_ack, bus_r);
    end
    bus_nxt = bus_st;

    // phase timer
    if (busy_nxt) begin
      tick_inc = tick_nxt + CntW'(1);
      tick_nxt = tick_inc;
      if (tick_inc >= lim) begin
        tick_nxt  = '0;
        phase_inc = phase_nxt + 5'd1;
        if (phase_inc >= phase_total(kind_nxt)) begin
          phase_nxt = '0;
          busy_nxt  = 1'b0;
          done_nxt  = 1'b1;
        end else begin
          phase_nxt = phase_inc;
          bus_nxt   = enter_phase(kind_nxt, phase_inc, in_data.sda_in, shift_nxt,
                                  ackreq_nxt, bus_st);
        end
      end
    end

    out_data_nxt.scl_drive_low = bus_nxt.scl;
    out_data_nxt.sda_drive_low = bus_nxt.sda;
    out_data_nxt.busy_res      = busy_nxt;
    out_data_nxt.done_res      = done_nxt;
    out_data_nxt.rx_byte       = bus_nxt.rx;
    out_data_nxt.ack_seen      = bus_nxt.ack;
  end

  // state, configuration and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= PHASE_TICKS_RESET;
      phase_r       <= '0;
      tick_r        <= '0;
      kind_r        <= KIND_START;
      busy_r        <= 1'b0;
      shift_r       <= '0;
      ackreq_r      <= 1'b0;
      bus_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) phase_ticks_r <= cfg_wdata;
      if (accept) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        kind_r      <= kind_nxt;
        busy_r      <= busy_nxt;
        shift_r     <= shift_nxt;
        ackreq_r    <= ackreq_nxt;
        bus_r       <= bus_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
